[design/sr_ack_pkg.sv]
package sr_ack_pkg;

    // counter width of the timeout and hold counters
    localparam int COUNT_WIDTH = 16;
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    // register map
    localparam int CFG_ADDR_WIDTH = 3;
    localparam logic REG_ACK_TIMEOUT = 1'b0;
    localparam logic REG_ERROR_HOLD  = 1'b1;
    localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd4;
    localparam logic [15:0] ERROR_HOLD_RESET  = 16'd8;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_RX    = 2'd2;

    // status codes at or above this carry no letters
    localparam logic [2:0] STATUS_NO_LETTERS = 3'd5;

    localparam logic [7:0] CHAR_HASH   = 8'h23;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_O      = 8'h4f;
    localparam logic [7:0] CHAR_K      = 8'h4b;

    // byte positions within a report frame
    localparam logic [2:0] POS_HASH   = 3'd0;
    localparam logic [2:0] POS_DIGIT  = 3'd1;
    localparam logic [2:0] POS_LETTER = 3'd2;
    localparam logic [2:0] POS_END    = 3'd5;

    // decoupling queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] unit_number;
        logic [2:0] unit_status;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       last;
        logic       error_active;
        logic       awaiting_ack;
        logic       ack_done;
        logic       timed_out;
        logic       start_dropped;
    } out_word_t;

    // classified word handed from front to back
    typedef struct packed {
        logic       is_frame;
        logic       has_letters;
        logic [3:0] unit_number;
        logic [2:0] unit_status;
        logic       error_active;
        logic       awaiting_ack;
        logic       ack_done;
        logic       timed_out;
        logic       start_dropped;
    } desc_t;

    function automatic logic [COUNT_WIDTH-1:0] load_count(logic [15:0] v);
        logic [COUNT_WIDTH-1:0] m;
        m = COUNT_WIDTH'(v);
        return (m == '0) ? COUNT_ONE : m;
    endfunction

    function automatic logic [7:0] status_letter(logic [2:0] code, logic [1:0] k);
        logic [7:0] b;
        b = 8'h00;
        case (code)
            3'd0: case (k) 2'd0: b = 8'h52; 2'd1: b = 8'h55; default: b = 8'h4e; endcase
            3'd1: case (k) 2'd0: b = 8'h54; 2'd1: b = 8'h45; default: b = 8'h50; endcase
            3'd2: case (k) 2'd0: b = 8'h50; 2'd1: b = 8'h52; default: b = 8'h45; endcase
            3'd3: case (k) 2'd0: b = 8'h53; 2'd1: b = 8'h54; default: b = 8'h50; endcase
            3'd4: case (k) 2'd0: b = 8'h45; 2'd1: b = 8'h52; default: b = 8'h52; endcase
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[design/status_report_with_ack_timeout.sv]
// status report sender with acknowledgement timeout
// input channel: a word (command, unit_number, unit_status, rx_byte) is taken
//   at a clock edge with push high and full low; the front updates the ack
//   state in that same cycle, so a new word can follow every cycle
// result channel: the oldest result sits on result while empty is low and
//   leaves at an edge with pop high; a start in idle gives three or six frame
//   words, every other command gives one status word, last marks the end
// path: a taken word is classified by the front, queued, then registered as result
// throughput: one result per cycle while pop is high, set by the single output
//   register; a start occupies the back end for three or six results, other words one
// stalls: a four-entry queue between front and back absorbs a held pop;
//   once it fills, full rises and input stops until pop resumes
// reset: idle, no ack awaited, error flag clear, counters zero,
//   ack_timeout_ticks 4, error_hold_ticks 8; no clearing pass is needed
// config: apb registers at 0 (ack_timeout_ticks) and 4 (error_hold_ticks),
//   written by the user only while the block is idle, not enforced by it
module status_report_with_ack_timeout
    import sr_ack_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  in_word_t                  item,
    output logic                      empty,
    input  logic                      pop,
    output out_word_t                 result,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CFG_ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic [15:0] ack_timeout_ticks;
    logic [15:0] error_hold_ticks;
    desc_t       front_desc;
    desc_t       back_desc;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;
    logic        accept;

    // apb never waits
    assign pready = 1'b1;

    // a word is taken whenever the queue has room
    assign full   = q_full;
    assign accept = push && !q_full;

    sr_ack_cfg u_cfg (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .ack_timeout_ticks (ack_timeout_ticks),
        .error_hold_ticks  (error_hold_ticks)
    );

    // front: ack state machine, classifies each word
    sr_ack_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .item              (item),
        .ack_timeout_ticks (ack_timeout_ticks),
        .error_hold_ticks  (error_hold_ticks),
        .desc              (front_desc)
    );

    sr_ack_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (accept),
        .wr_data (front_desc),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (back_desc),
        .empty   (q_empty)
    );

    // back: expands frames into bytes, one result per cycle while popped
    sr_ack_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc       (back_desc),
        .desc_empty (q_empty),
        .desc_pop   (q_pop),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

[design/sr_ack_cfg.sv]
module sr_ack_cfg
    import sr_ack_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CFG_ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic [15:0]               ack_timeout_ticks,
    output logic [15:0]               error_hold_ticks
);

    logic [15:0] ack_timeout_reg;
    logic [15:0] error_hold_reg;
    logic        wr_en;

    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
            error_hold_reg  <= ERROR_HOLD_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_ACK_TIMEOUT)
                ack_timeout_reg <= pwdata[15:0];
            else
                error_hold_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_ACK_TIMEOUT)
            prdata = {16'h0000, ack_timeout_reg};
        else
            prdata = {16'h0000, error_hold_reg};
    end

    assign ack_timeout_ticks = ack_timeout_reg;
    assign error_hold_ticks  = error_hold_reg;

endmodule

[design/sr_ack_front.sv]
module sr_ack_front
    import sr_ack_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  in_word_t    item,
    input  logic [15:0] ack_timeout_ticks,
    input  logic [15:0] error_hold_ticks,
    output desc_t       desc
);

    logic                   phase_reg, phase_next;
    logic                   seen_o_reg, seen_o_next;
    logic                   error_reg, error_next;
    logic [COUNT_WIDTH-1:0] timeout_reg, timeout_next;
    logic [COUNT_WIDTH-1:0] hold_reg, hold_next;
    logic                   frame;
    logic                   done;
    logic                   tmo;
    logic                   dropped;

    always_comb
    begin
        phase_next   = phase_reg;
        seen_o_next  = seen_o_reg;
        error_next   = error_reg;
        timeout_next = timeout_reg;
        hold_next    = hold_reg;
        frame        = 1'b0;
        done         = 1'b0;
        tmo          = 1'b0;
        dropped      = 1'b0;
        case (item.command)
            CMD_START:
            begin
                if (phase_reg)
                    dropped = 1'b1;
                else
                begin
                    phase_next   = 1'b1;
                    seen_o_next  = 1'b0;
                    timeout_next = load_count(ack_timeout_ticks);
                    frame        = 1'b1;
                end
            end
            CMD_RX:
            begin
                if (phase_reg)
                begin
                    if (!seen_o_reg)
                    begin
                        if (item.rx_byte == CHAR_O)
                            seen_o_next = 1'b1;
                    end
                    else if (item.rx_byte == CHAR_K)
                    begin
                        phase_next   = 1'b0;
                        seen_o_next  = 1'b0;
                        timeout_next = '0;
                        error_next   = 1'b0;
                        hold_next    = '0;
                        done         = 1'b1;
                    end
                end
            end
            CMD_TICK:
            begin
                // hold counts first, so a hold started below is not counted now
                if (error_reg)
                begin
                    if (hold_reg > COUNT_ONE)
                        hold_next = hold_reg - COUNT_ONE;
                    else
                    begin
                        hold_next  = '0;
                        error_next = 1'b0;
                    end
                end
                if (phase_reg)
                begin
                    if (timeout_reg > COUNT_ONE)
                        timeout_next = timeout_reg - COUNT_ONE;
                    else
                    begin
                        timeout_next = '0;
                        phase_next   = 1'b0;
                        seen_o_next  = 1'b0;
                        error_next   = 1'b1;
                        hold_next    = load_count(error_hold_ticks);
                        tmo          = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= 1'b0;
            seen_o_reg  <= 1'b0;
            error_reg   <= 1'b0;
            timeout_reg <= '0;
            hold_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            seen_o_reg  <= seen_o_next;
            error_reg   <= error_next;
            timeout_reg <= timeout_next;
            hold_reg    <= hold_next;
        end
    end

    always_comb
    begin
        desc.is_frame      = frame;
        desc.has_letters   = item.unit_status < STATUS_NO_LETTERS;
        desc.unit_number   = item.unit_number;
        desc.unit_status   = item.unit_status;
        desc.error_active  = error_next;
        desc.awaiting_ack  = phase_next;
        desc.ack_done      = done;
        desc.timed_out     = tmo;
        desc.start_dropped = dropped;
    end

endmodule

[design/sr_ack_fifo.sv]
module sr_ack_fifo
    import sr_ack_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t wr_data,
    output logic  full,
    input  logic  pop,
    output desc_t rd_data,
    output logic  empty
);

    desc_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W:0]   count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full    = count_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[design/sr_ack_back.sv]
module sr_ack_back
    import sr_ack_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  desc_t     desc,
    input  logic      desc_empty,
    output logic      desc_pop,
    output out_word_t result,
    output logic      empty,
    input  logic      pop
);

    logic [2:0] pos_reg, pos_next;
    logic       out_valid_reg;
    out_word_t  result_reg;
    out_word_t  word;
    logic       item_done;
    logic       load_out;

    always_comb
    begin
        word.tx_valid      = desc.is_frame;
        word.tx_byte       = 8'h00;
        word.last          = 1'b1;
        word.error_active  = desc.error_active;
        word.awaiting_ack  = desc.awaiting_ack;
        word.ack_done      = desc.ack_done;
        word.timed_out     = desc.timed_out;
        word.start_dropped = desc.start_dropped;
        if (desc.is_frame)
        begin
            word.last = pos_reg == POS_END;
            case (pos_reg)
                POS_HASH:  word.tx_byte = CHAR_HASH;
                POS_DIGIT: word.tx_byte = CHAR_ZERO + {4'h0, desc.unit_number};
                POS_END:   word.tx_byte = CHAR_DOLLAR;
                default:   word.tx_byte = status_letter(desc.unit_status,
                                                        2'(pos_reg - POS_LETTER));
            endcase
        end
    end

    assign item_done = word.last;
    assign load_out  = !desc_empty && (!out_valid_reg || pop);
    assign desc_pop  = load_out && item_done;

    always_comb
    begin
        pos_next = pos_reg;
        if (load_out)
        begin
            if (item_done)
                pos_next = POS_HASH;
            else if (pos_reg == POS_DIGIT && !desc.has_letters)
                pos_next = POS_END;
            else
                pos_next = pos_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_HASH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            result_reg <= word;
    end

    assign result = result_reg;
    assign empty  = !out_valid_reg;

endmodule

[tb/status_report_with_ack_timeout_test.sv]
module status_report_with_ack_timeout_test;
    import sr_ack_pkg::*;

    // command code with no meaning to the block
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // cycles with no handshake before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // settle time after the last expected word
    localparam int DRAIN_CYCLES = 8;

    logic                      clk;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    in_word_t                  item;
    logic                      empty;
    logic                      pop;
    out_word_t                 result;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [CFG_ADDR_WIDTH-1:0] paddr;
    logic [31:0]               pwdata;
    logic [31:0]               prdata;
    logic                      pready;

    status_report_with_ack_timeout dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // words waiting to be pushed, and result words the sender model says are due
    in_word_t  items_to_send[$];
    out_word_t due_words[$];

    // idling odds, in percent, for each side
    int sender_idle_pct;
    int receiver_idle_pct;

    int mismatches;
    int words_queued;
    int words_accepted;
    int results_seen;
    int settings_run;
    int acks_seen;
    int timeouts_seen;
    int drops_seen;
    int idle_cycles;

    // sender model: register copies and ack state
    logic [15:0]            cfg_ack_timeout;
    logic [15:0]            cfg_error_hold;
    logic                   awaiting;
    logic                   seen_o;
    logic                   error_on;
    logic [COUNT_WIDTH-1:0] ack_left;
    logic [COUNT_WIDTH-1:0] hold_left;

    // three letters per status code below the no-letter range
    string status_names[5] = '{"RUN", "TEP", "PRE", "STP", "ERR"};

    // a register value of zero counts as one tick
    function automatic logic [COUNT_WIDTH-1:0] count_start(logic [15:0] v);
        logic [COUNT_WIDTH-1:0] m;
        m = COUNT_WIDTH'(v);
        return (m == '0) ? COUNT_WIDTH'(1) : m;
    endfunction

    // one frame byte word, flags taken from the model after the start
    function automatic void queue_frame_byte(logic [7:0] b);
        out_word_t w;
        w = '0;
        w.tx_valid     = 1'b1;
        w.tx_byte      = b;
        w.error_active = error_on;
        w.awaiting_ack = awaiting;
        due_words.push_back(w);
    endfunction

    // advance the sender model by one accepted word and queue its results
    function automatic void predict_report(in_word_t w);
        out_word_t r;
        logic      done;
        logic      tmo;
        logic      dropped;
        done    = 1'b0;
        tmo     = 1'b0;
        dropped = 1'b0;
        case (w.command)
            CMD_START:
            begin
                if (awaiting)
                begin
                    dropped = 1'b1;
                    drops_seen++;
                end
                else
                begin
                    awaiting = 1'b1;
                    seen_o   = 1'b0;
                    ack_left = count_start(cfg_ack_timeout);
                    queue_frame_byte(CHAR_HASH);
                    queue_frame_byte(CHAR_ZERO + 8'(w.unit_number));
                    if (w.unit_status < STATUS_NO_LETTERS)
                    begin
                        for (int i = 0; i < 3; i++)
                            queue_frame_byte(status_names[w.unit_status][i]);
                    end
                    queue_frame_byte(CHAR_DOLLAR);
                    // closing '$' carries the end mark
                    r = due_words.pop_back();
                    r.last = 1'b1;
                    due_words.push_back(r);
                    return;
                end
            end
            CMD_RX:
            begin
                if (awaiting)
                begin
                    if (!seen_o)
                    begin
                        if (w.rx_byte == CHAR_O)
                            seen_o = 1'b1;
                    end
                    else if (w.rx_byte == CHAR_K)
                    begin
                        // full ack also ends any error hold
                        awaiting  = 1'b0;
                        seen_o    = 1'b0;
                        ack_left  = '0;
                        error_on  = 1'b0;
                        hold_left = '0;
                        done      = 1'b1;
                        acks_seen++;
                    end
                end
            end
            CMD_TICK:
            begin
                // hold counts down before the ack timeout
                if (error_on)
                begin
                    if (hold_left > 1)
                        hold_left = hold_left - 1'b1;
                    else
                    begin
                        hold_left = '0;
                        error_on  = 1'b0;
                    end
                end
                if (awaiting)
                begin
                    if (ack_left > 1)
                        ack_left = ack_left - 1'b1;
                    else
                    begin
                        // timeout restarts a running hold at full length
                        ack_left  = '0;
                        awaiting  = 1'b0;
                        seen_o    = 1'b0;
                        error_on  = 1'b1;
                        hold_left = count_start(cfg_error_hold);
                        tmo       = 1'b1;
                        timeouts_seen++;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r               = '0;
        r.last          = 1'b1;
        r.error_active  = error_on;
        r.awaiting_ack  = awaiting;
        r.ack_done      = done;
        r.timed_out     = tmo;
        r.start_dropped = dropped;
        due_words.push_back(r);
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // word with the given command and byte, the other fields random
    function automatic in_word_t make_word(logic [1:0] cmd, logic [7:0] rx);
        in_word_t w;
        w.command     = cmd;
        w.unit_number = 4'($urandom_range(0, 15));
        w.unit_status = 3'($urandom_range(0, 7));
        w.rx_byte     = rx;
        return w;
    endfunction

    function automatic in_word_t start_word(logic [3:0] unit, logic [2:0] status);
        in_word_t w;
        w             = make_word(CMD_START, 8'($urandom_range(0, 255)));
        w.unit_number = unit;
        w.unit_status = status;
        return w;
    endfunction

    function automatic in_word_t tick_word();
        return make_word(CMD_TICK, 8'($urandom_range(0, 255)));
    endfunction

    function automatic in_word_t rx_word(logic [7:0] b);
        return make_word(CMD_RX, b);
    endfunction

    task automatic add(in_word_t w);
        items_to_send.push_back(w);
        words_queued++;
    endtask

    // tick or stray byte, as may fall between a frame and its ack
    task automatic add_filler();
        if ($urandom_range(0, 1) == 0)
            add(tick_word());
        else
            add(rx_word(8'($urandom_range(0, 255))));
    endtask

    // mostly frames with acks or timeouts, the rest broken acks and noise
    task automatic queue_random_items(int count);
        int target;
        int kind;
        int n;
        target = words_queued + count;
        while (words_queued < target)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 5)
            begin
                // frame, some filler, then a complete ack
                add(make_word(CMD_START, 8'($urandom_range(0, 255))));
                n = $urandom_range(0, 4);
                repeat (n) add_filler();
                add(rx_word(CHAR_O));
                n = $urandom_range(0, 2);
                repeat (n) add_filler();
                add(rx_word(CHAR_K));
            end
            else if (kind < 7)
            begin
                // frame left unanswered so the timeout and hold run
                add(make_word(CMD_START, 8'($urandom_range(0, 255))));
                n = $urandom_range(1, 20);
                repeat (n)
                begin
                    if ($urandom_range(0, 4) == 0)
                        add(rx_word(8'($urandom_range(0, 255))));
                    else
                        add(tick_word());
                end
            end
            else if (kind < 8)
            begin
                // ack out of order and a second start while awaiting
                add(make_word(CMD_START, 8'($urandom_range(0, 255))));
                add(rx_word(CHAR_K));
                add(rx_word(8'($urandom_range(0, 255))));
                add(make_word(CMD_START, 8'($urandom_range(0, 255))));
                n = $urandom_range(0, 3);
                repeat (n) add(tick_word());
            end
            else
            begin
                // plain noise on every command, the unused one included
                n = $urandom_range(1, 4);
                repeat (n)
                    add(make_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255))));
            end
        end
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_reg(logic idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_ACK_TIMEOUT)
            cfg_ack_timeout = value[15:0];
        else
            cfg_error_hold = value[15:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // block is idle once every word went in and every result came out
    task automatic drain();
        while (items_to_send.size() != 0 || due_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(logic [31:0] ack, logic [31:0] hold,
                             int send_idle, int recv_idle, int count);
        write_reg(REG_ACK_TIMEOUT, ack);
        write_reg(REG_ERROR_HOLD, hold);
        sender_idle_pct   = send_idle;
        receiver_idle_pct = recv_idle;
        queue_random_items(count);
        drain();
        settings_run++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // driver: offer the oldest pending word at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && items_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct)
        begin
            push <= 1'b1;
            item <= items_to_send[0];
        end
        else
            push <= 1'b0;
    end

    // driver: a word taken at the rising edge goes through the model
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            predict_report(item);
            void'(items_to_send.pop_front());
            words_accepted++;
        end
    end

    // monitor: random back pressure on the result side
    always @(negedge clk)
    begin
        pop <= rst_n && ($urandom_range(99) >= receiver_idle_pct);
    end

    // monitor: each popped word against the oldest expected one
    always @(posedge clk)
    begin : result_check
        out_word_t want;
        if (rst_n && pop && !empty)
        begin
            results_seen++;
            if (due_words.size() == 0)
            begin
                $error("result word %h arrived with nothing expected", result);
                mismatches++;
            end
            else
            begin
                want = due_words.pop_front();
                check_field("tx_valid", 8'(want.tx_valid), 8'(result.tx_valid));
                check_field("tx_byte", want.tx_byte, result.tx_byte);
                check_field("last", 8'(want.last), 8'(result.last));
                check_field("error_active", 8'(want.error_active),
                            8'(result.error_active));
                check_field("awaiting_ack", 8'(want.awaiting_ack), 8'(result.awaiting_ack));
                check_field("ack_done", 8'(want.ack_done), 8'(result.ack_done));
                check_field("timed_out", 8'(want.timed_out), 8'(result.timed_out));
                check_field("start_dropped", 8'(want.start_dropped), 8'(result.start_dropped));
            end
        end
    end

    // watchdog: too long without any handshake means the block hung
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[status_report_with_ack_timeout] ERROR");
            $finish;
        end
    end

    initial
    begin
        // every input known from time zero, reset held low
        rst_n             = 1'b0;
        push              = 1'b0;
        item              = '0;
        pop               = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        mismatches        = 0;
        words_queued      = 0;
        words_accepted    = 0;
        results_seen      = 0;
        settings_run      = 0;
        acks_seen         = 0;
        timeouts_seen     = 0;
        drops_seen        = 0;
        idle_cycles       = 0;
        sender_idle_pct   = 37;
        receiver_idle_pct = 47;
        cfg_ack_timeout   = ACK_TIMEOUT_RESET;
        cfg_error_hold    = ERROR_HOLD_RESET;
        awaiting          = 1'b0;
        seen_o            = 1'b0;
        error_on          = 1'b0;
        ack_left          = '0;
        hold_left         = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part on reset register values (timeout 4, hold 8)
        add(start_word(4'd0, 3'd0));
        add(rx_word(CHAR_K));            // k before any o is ignored
        add(rx_word(CHAR_O));
        add(rx_word(CHAR_O));            // second o is just another byte
        add(rx_word(CHAR_K));            // ack completes
        add(rx_word(CHAR_O));            // byte in idle is ignored
        add(start_word(4'd9, 3'd4));
        add(start_word(4'd3, 3'd1));     // dropped, ack still awaited
        repeat (4) add(tick_word());     // timeout on the fourth tick
        add(tick_word());                // hold counting
        add(start_word(4'd15, 3'd7));    // no letters, digit past '9'
        add(rx_word(CHAR_O));
        add(rx_word(CHAR_K));            // ack during hold clears the flag
        add(start_word(4'd10, 3'd5));
        repeat (4) add(tick_word());
        add(start_word(4'd1, 3'd6));
        repeat (4) add(tick_word());     // timeout in hold restarts it
        add(make_word(CMD_UNUSED, 8'hff)); // unused command
        queue_random_items(20);
        drain();
        settings_run++;

        // receiver idles more than the sender
        run_phase(32'd1, 32'd1, 37, 47, 20);
        // zero after masking, and plain zero, both act as one tick
        run_phase(32'h0001_0000, 32'd0, 47, 37, 20);
        run_phase(32'd3, 32'd5, 47, 37, 20);
        // no idling on either side
        run_phase(32'hffff_ffff, 32'd65535, 0, 0, 20);
        run_phase(32'd2, 32'd12, 0, 0, 20);

        if (due_words.size() != 0)
        begin
            $error("%0d result words never arrived", due_words.size());
            mismatches++;
        end
        $display("covered %0d input words and %0d result words over %0d register settings",
                 words_accepted, results_seen, settings_run);
        $display("acks %0d, timeouts %0d, dropped starts %0d, mismatches %0d",
                 acks_seen, timeouts_seen, drops_seen, mismatches);
        if (mismatches == 0)
            $display("[status_report_with_ack_timeout] OK");
        else
            $display("[status_report_with_ack_timeout] ERROR");
        $finish;
    end

endmodule
